// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the peak-to-peak meter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that must hold at every clock edge outside reset.
`define DPPM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define DPPM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DPPM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/dppm_pkg.sv =====
// ----------------------------------------------------------------------------
// dppm_pkg
// Types and constants shared by the decimated peak-to-peak meter.
// ----------------------------------------------------------------------------
package dppm_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int VAL_W      = 16;
  localparam int REG_W      = 16;
  localparam int NUM_CH     = 3;
  localparam int CH_W       = 2;
  localparam int WIN_CNT_W  = 9;
  localparam int WINDOW_DEF = 16;

  // Shared multiplier operands: sample by scale, then product by 1000, and
  // at the end of a window each peak by the reciprocal of WINDOW.
  localparam int WIN_LOG_MAX = 8;
  localparam int RECIP_SH    = VAL_W + WIN_LOG_MAX;
  localparam int MUL_A_W     = 28;
  localparam int MUL_B_W     = RECIP_SH;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int THOUSAND    = 1000;

  // Divider: dividend holds scale * sample * 1000, divisor is 16 bits.
  localparam int DIV_W      = 38;
  localparam int DIVR_W     = 16;

  // Configuration port.
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEFF  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD = 2'd2;

  localparam logic [REG_W-1:0] SCALE_RST  = 16'd1;
  localparam logic [REG_W-1:0] COEFF_RST  = 16'd1000;
  localparam logic [REG_W-1:0] PERIOD_RST = 16'd1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic [SAMPLE_W-1:0] sample_c;
  } dppm_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] swing_a;
    logic [VAL_W-1:0] swing_b;
    logic [VAL_W-1:0] swing_c;
  } dppm_out_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } dppm_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } dppm_div_sts_t;

endpackage

// ===== hw/rtl/dppm_div.sv =====
// ----------------------------------------------------------------------------
// dppm_div
// Iterative restoring divider, one quotient bit per cycle, used to divide
// each scaled sample by the coefficient register.
// ----------------------------------------------------------------------------
module dppm_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dppm_pkg::dppm_div_req_t req_i,
  output dppm_pkg::dppm_div_sts_t sts_o
);

  localparam int DivW  = dppm_pkg::DIV_W;
  localparam int DivrW = dppm_pkg::DIVR_W;
  localparam int CntW  = $clog2(DivW);
  localparam logic [CntW-1:0] CntLast = CntW'(DivW - 1);

  logic [DivW-1:0]  quo_q;
  logic [DivrW-1:0] rem_q;
  logic [DivrW-1:0] dvs_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DivrW:0]   shifted;
  logic [DivrW:0]   diff;
  logic             fits;

  // A zero divisor always fits, so the quotient comes out as all ones.
  assign shifted = {rem_q, quo_q[DivW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivW-2:0], fits};
      rem_q <= fits ? diff[DivrW-1:0] : shifted[DivrW-1:0];
    end
  end

  assign sts_o.done     = done_q;
  assign sts_o.quotient = quo_q;

endmodule

// ===== hw/rtl/decimated_peak_to_peak_meter.sv =====
// ----------------------------------------------------------------------------
// decimated_peak_to_peak_meter
// Three-channel scaled peak-to-peak meter over a decimated window of ticks.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 word
//  in       input      in_valid_i / in_stall_o   dppm_in_t  (three samples)
//  out      output     out_valid_o / out_stall_i dppm_out_t (three swings)
//  cfg      input      APB psel/penable/pwrite   16-bit registers at 4*i
//
// A tick dropped by decimation advances the decimation count. A tick that
// enters the window goes, per channel, through the scale and thousand
// multiplies, the shared one-bit-per-cycle divider and one compare. The
// tick that fills the window adds one reciprocal multiply per peak and an
// output load that waits while a stalled output still holds the last word.
// Reset clears the window, the decimation count and the registers at once.
// A stalled output holds the last word while the next tick is processed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module decimated_peak_to_peak_meter #(
  parameter int unsigned WINDOW = dppm_pkg::WINDOW_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  dppm_pkg::dppm_in_t                in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output dppm_pkg::dppm_out_t               out_word_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dppm_pkg::APB_AW-1:0]       paddr,
  input  logic [dppm_pkg::APB_DW-1:0]       pwdata,
  output logic [dppm_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  localparam int ValW    = dppm_pkg::VAL_W;
  localparam int RegW    = dppm_pkg::REG_W;
  localparam int NumCh   = dppm_pkg::NUM_CH;
  localparam int ChW     = dppm_pkg::CH_W;
  localparam int WinCntW = dppm_pkg::WIN_CNT_W;
  localparam int MulAW   = dppm_pkg::MUL_A_W;
  localparam int MulBW   = dppm_pkg::MUL_B_W;
  localparam int MulPW   = dppm_pkg::MUL_P_W;
  localparam int RecipSh = dppm_pkg::RECIP_SH;
  localparam int DivW    = dppm_pkg::DIV_W;
  localparam int SampW   = dppm_pkg::SAMPLE_W;
  localparam int AddrW   = dppm_pkg::APB_AW;
  localparam int DataW   = dppm_pkg::APB_DW;
  localparam int IdxW    = dppm_pkg::REG_IDX_W;

  localparam logic [WinCntW-1:0] WinLast = WinCntW'(WINDOW);
  localparam logic [ChW-1:0]     LastCh  = ChW'(NumCh - 1);
  localparam logic [MulBW-1:0]   Thou    = MulBW'(dppm_pkg::THOUSAND);
  // The rounded-up reciprocal of WINDOW gives the exact floor quotient for
  // any 16-bit peak once the fraction bits are dropped.
  localparam logic [MulBW-1:0]   WinRecip =
    MulBW'(((64'd1 << RecipSh) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL1  = 3'd1;
  localparam logic [2:0] S_MUL2  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_TRACK = 3'd4;
  localparam logic [2:0] S_HIGH  = 3'd5;
  localparam logic [2:0] S_LOW   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  // Control and window state.
  logic [2:0]          state_q, state_d;
  logic [ChW-1:0]      ch_q, ch_d;
  logic [WinCntW-1:0]  win_q, win_d;
  logic [RegW-1:0]     decim_q, decim_d;
  logic [ValW-1:0]     low_q  [NumCh];
  logic [ValW-1:0]     low_d  [NumCh];
  logic [ValW-1:0]     high_q [NumCh];
  logic [ValW-1:0]     high_d [NumCh];
  logic                out_valid_q, out_valid_d;

  // Configuration registers.
  logic [RegW-1:0]     scale_q, coeff_q, period_q;

  // Datapath registers.
  logic [SampW-1:0]    samp_q  [NumCh];
  logic [MulAW-1:0]    mul_q;
  logic [ValW-1:0]     hq_q;
  logic [ValW-1:0]     swing_q [NumCh];
  dppm_pkg::dppm_out_t out_q;

  logic [MulAW-1:0]    mul_a;
  logic [MulBW-1:0]    mul_b;
  logic [MulPW-1:0]    mul_p;
  logic [RegW-1:0]     decim_inc;
  logic [WinCntW-1:0]  win_inc;
  logic [ValW-1:0]     quo_lo;
  logic [ValW-1:0]     win_quo;
  logic                load_samp, load_mul, load_hq, load_sw, emit_go;
  logic                cfg_wr;
  logic [IdxW-1:0]     cfg_idx;

  dppm_pkg::dppm_div_req_t div_req;
  dppm_pkg::dppm_div_sts_t div_sts;

  dppm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .sts_o  (div_sts)
  );

  // One multiplier serves both scaling steps and the division by WINDOW.
  always_comb begin
    case (state_q)
      S_MUL1: begin
        mul_a = MulAW'(samp_q[ch_q]);
        mul_b = MulBW'(scale_q);
      end
      S_HIGH: begin
        mul_a = MulAW'(high_q[ch_q]);
        mul_b = WinRecip;
      end
      S_LOW: begin
        mul_a = MulAW'(low_q[ch_q]);
        mul_b = WinRecip;
      end
      default: begin
        mul_a = mul_q;
        mul_b = Thou;
      end
    endcase
  end

  assign mul_p = MulPW'(mul_a) * MulPW'(mul_b);

  assign decim_inc = decim_q + RegW'(1);
  assign win_inc   = win_q + WinCntW'(1);
  assign quo_lo    = div_sts.quotient[ValW-1:0];
  assign win_quo   = mul_p[RecipSh +: ValW];

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    win_d       = win_q;
    decim_d     = decim_q;
    low_d       = low_q;
    high_d      = high_q;
    out_valid_d = out_valid_q;
    load_samp   = 1'b0;
    load_mul    = 1'b0;
    load_hq     = 1'b0;
    load_sw     = 1'b0;
    emit_go     = 1'b0;
    div_req     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          load_samp = 1'b1;
          // A period of zero lets every tick through, like a period of one.
          if (decim_inc >= period_q) begin
            decim_d = '0;
            ch_d    = '0;
            state_d = S_MUL1;
          end else begin
            decim_d = decim_inc;
          end
        end
      end
      S_MUL1: begin
        load_mul = 1'b1;
        state_d  = S_MUL2;
      end
      S_MUL2: begin
        div_req.start    = 1'b1;
        div_req.dividend = DivW'(mul_p);
        div_req.divisor  = coeff_q;
        state_d          = S_DIV;
      end
      S_DIV: begin
        if (div_sts.done) begin
          state_d = S_TRACK;
        end
      end
      S_TRACK: begin
        if (quo_lo < low_q[ch_q]) begin
          low_d[ch_q] = quo_lo;
        end
        if (quo_lo > high_q[ch_q]) begin
          high_d[ch_q] = quo_lo;
        end
        if (ch_q == LastCh) begin
          win_d = win_inc;
          if (win_inc == WinLast) begin
            ch_d    = '0;
            state_d = S_HIGH;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = S_MUL1;
        end
      end
      S_HIGH: begin
        load_hq = 1'b1;
        state_d = S_LOW;
      end
      S_LOW: begin
        load_sw = 1'b1;
        if (ch_q == LastCh) begin
          state_d = S_EMIT;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = S_HIGH;
        end
      end
      S_EMIT: begin
        // Wait until the output register is free, then start a new window.
        if (!out_valid_q || !out_stall_i) begin
          emit_go     = 1'b1;
          out_valid_d = 1'b1;
          win_d       = '0;
          for (int i = 0; i < NumCh; i++) begin
            low_d[i]  = '1;
            high_d[i] = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= '0;
      win_q       <= '0;
      decim_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumCh; i++) begin
        low_q[i]  <= '1;
        high_q[i] <= '0;
      end
      scale_q  <= dppm_pkg::SCALE_RST;
      coeff_q  <= dppm_pkg::COEFF_RST;
      period_q <= dppm_pkg::PERIOD_RST;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      win_q       <= win_d;
      decim_q     <= decim_d;
      out_valid_q <= out_valid_d;
      low_q       <= low_d;
      high_q      <= high_d;
      if (cfg_wr) begin
        case (cfg_idx)
          dppm_pkg::REG_SCALE:  scale_q  <= pwdata[RegW-1:0];
          dppm_pkg::REG_COEFF:  coeff_q  <= pwdata[RegW-1:0];
          dppm_pkg::REG_PERIOD: period_q <= pwdata[RegW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_samp) begin
      samp_q[0] <= in_word_i.sample_a;
      samp_q[1] <= in_word_i.sample_b;
      samp_q[2] <= in_word_i.sample_c;
    end
    if (load_mul) begin
      mul_q <= mul_p[MulAW-1:0];
    end
    if (load_hq) begin
      hq_q <= win_quo;
    end
    if (load_sw) begin
      swing_q[ch_q] <= hq_q - win_quo;
    end
    if (emit_go) begin
      out_q.swing_a <= swing_q[0];
      out_q.swing_b <= swing_q[1];
      out_q.swing_c <= swing_q[2];
    end
  end

  always_comb begin
    case (cfg_idx)
      dppm_pkg::REG_SCALE:  prdata = DataW'(scale_q);
      dppm_pkg::REG_COEFF:  prdata = DataW'(coeff_q);
      dppm_pkg::REG_PERIOD: prdata = DataW'(period_q);
      default:              prdata = '0;
    endcase
  end

  assign pready      = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `DPPM_ASSERT_IMP(a_idle_win, clk_i, rst_ni, state_q == S_IDLE, win_q < WinLast, "window count at or past WINDOW while idle")
  `DPPM_ASSERT_IMP(a_div_done, clk_i, rst_ni, div_sts.done, state_q == S_DIV, "divider finished outside the divide state")
  `DPPM_ASSERT(a_ch_range, clk_i, rst_ni, ch_q <= LastCh, "channel index out of range")
  `DPPM_ASSERT_NXT(a_emit_clear, clk_i, rst_ni, emit_go, out_valid_q && win_q == '0 && low_q[0] == '1 && high_q[2] == '0, "window not restarted after a result")

endmodule

// ===== bench/tb_decimated_peak_to_peak_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimated_peak_to_peak_meter
// Self-checking bench for the decimated three-channel peak-to-peak meter.
// A directed table covers the sample extremes, a zero coefficient, a zero
// decimation period and wrapped scaling. Random phases follow, each under its
// own register setting. Every sample word is scored against an in-bench model
// of the window and compared with the swing words. Both sides idle at random,
// and the receiver holds off once for long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_decimated_peak_to_peak_meter;
  import dppm_pkg::*;

  localparam int unsigned WIN          = WINDOW_DEF;
  localparam int unsigned SETTLE_CYCLES = 500;
  localparam int unsigned HOLD_CYCLES  = 6000;
  localparam int unsigned QUIET_LIMIT  = 20000;
  localparam int unsigned NUM_PHASES   = 12;
  localparam int unsigned PHASE_WORDS  = 140;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;
  typedef enum int {SPREAD_FULL, SPREAD_EDGES, SPREAD_NARROW} spread_e;

  typedef struct {
    row_kind_e              kind;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic [REG_W-1:0]       value;
    dppm_in_t               word;
    bit                     typed;
    dppm_out_t              swing;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  dppm_in_t            in_word_i;
  logic                out_valid_o;
  logic                out_stall_i;
  dppm_out_t           out_word_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // Mirror of the block's registers and window state.
  logic [REG_W-1:0]     reg_scale;
  logic [REG_W-1:0]     reg_coeff;
  logic [REG_W-1:0]     reg_period;
  logic [15:0]          tick_count;
  logic [WIN_CNT_W-1:0] fill_count;
  logic [VAL_W-1:0]     win_low  [NUM_CH];
  logic [VAL_W-1:0]     win_high [NUM_CH];

  dppm_out_t   swing_q [$];
  stim_row_t   directed_rows [$];

  bit          tx_gappy;
  bit          rx_gappy;
  bit          rx_hold_req;
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned swings_checked;
  int unsigned settings_applied;
  int unsigned holds_done;
  int unsigned quiet_cycles;

  decimated_peak_to_peak_meter #(
    .WINDOW (WIN)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [VAL_W-1:0] got,
                             input logic [VAL_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  function automatic void clear_window();
    fill_count = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      win_low[ch]  = '1;
      win_high[ch] = '0;
    end
  endfunction

  // Advances the window by one sample word; returns 1 when a swing word is due.
  function automatic bit predict_swing(input dppm_in_t w, output dppm_out_t sw);
    logic [SAMPLE_W-1:0] raw  [NUM_CH];
    logic [VAL_W-1:0]    v    [NUM_CH];
    logic [VAL_W-1:0]    diff [NUM_CH];
    logic [63:0]         num;
    raw[0] = w.sample_a;
    raw[1] = w.sample_b;
    raw[2] = w.sample_c;
    sw = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (reg_coeff == '0) begin
        v[ch] = '1;
      end else begin
        num   = 64'(reg_scale) * 64'(raw[ch]) * 64'(THOUSAND);
        v[ch] = VAL_W'(num / 64'(reg_coeff));
      end
    end
    tick_count = tick_count + 16'd1;
    if (tick_count < reg_period) return 1'b0;
    tick_count = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (v[ch] < win_low[ch])  win_low[ch]  = v[ch];
      if (v[ch] > win_high[ch]) win_high[ch] = v[ch];
    end
    fill_count = fill_count + 1'b1;
    if (fill_count < WIN) return 1'b0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      diff[ch] = VAL_W'(win_high[ch] / WIN) - VAL_W'(win_low[ch] / WIN);
    end
    sw.swing_a = diff[0];
    sw.swing_b = diff[1];
    sw.swing_c = diff[2];
    clear_window();
    return 1'b1;
  endfunction

  function automatic dppm_in_t make_word(input spread_e spread);
    logic [SAMPLE_W-1:0] s [NUM_CH];
    int                  base;
    int                  x;
    dppm_in_t            w;
    base = $urandom_range(0, 4095);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      case (spread)
        SPREAD_EDGES: begin
          case ($urandom_range(0, 2))
            0:       s[ch] = '0;
            1:       s[ch] = '1;
            default: s[ch] = SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
          endcase
        end
        SPREAD_NARROW: begin
          x = base + int'($urandom_range(0, 64)) - 32;
          if (x < 0) x = 0;
          if (x > 4095) x = 4095;
          s[ch] = SAMPLE_W'(x);
        end
        default: s[ch] = SAMPLE_W'($urandom);
      endcase
    end
    w.sample_a = s[0];
    w.sample_b = s[1];
    w.sample_c = s[2];
    return w;
  endfunction

  function automatic void add_sample(input logic [SAMPLE_W-1:0] a,
                                     input logic [SAMPLE_W-1:0] b,
                                     input logic [SAMPLE_W-1:0] c,
                                     input bit typed = 1'b0,
                                     input dppm_out_t sw = '0);
    stim_row_t row;
    row.kind       = ROW_SAMPLE;
    row.reg_idx    = REG_SCALE;
    row.value      = '0;
    row.word       = '{sample_a: a, sample_b: b, sample_c: c};
    row.typed      = typed;
    row.swing      = sw;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void add_write(input logic [REG_IDX_W-1:0] idx,
                                    input logic [REG_W-1:0] value);
    stim_row_t row;
    row.kind    = ROW_WRITE;
    row.reg_idx = idx;
    row.value   = value;
    row.word    = '0;
    row.typed   = 1'b0;
    row.swing   = '0;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Write a register, then read it straight back.
  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [REG_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SCALE:  reg_scale  = value;
      REG_COEFF:  reg_coeff  = value;
      REG_PERIOD: reg_period = value;
      default: ;
    endcase
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[REG_W-1:0] !== value) begin
      report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                idx, prdata[REG_W-1:0], value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_applied++;
  endtask

  // Lets the block finish any tick in flight before the registers change.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (swing_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_and_predict(input dppm_in_t w, input bit typed,
                                  input dppm_out_t typed_sw);
    int unsigned gap;
    bit          fired;
    dppm_out_t   sw;
    gap = tx_gappy ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    words_sent++;
    fired = predict_swing(w, sw);
    if (typed) sw = typed_sw;
    if (fired) swing_q.insert(swing_q.size(), sw);
  endtask

  // Receiver: random stalls that overlap the valid word, plus one long hold.
  initial begin : receiver
    int unsigned n;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        holds_done++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        n = rx_gappy ? $urandom_range(0, 16) : 0;
        if (n != 0) begin
          out_stall_i <= 1'b1;
          do @(posedge clk_i); while (out_valid_o !== 1'b1);
          repeat (n - 1) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_stall_i === 1'b0));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (swing_q.size() == 0) begin
        report_mismatch("swing word arrived with none expected");
      end else begin
        check_field("swing_a", out_word_o.swing_a, swing_q[0].swing_a);
        check_field("swing_b", out_word_o.swing_b, swing_q[0].swing_b);
        check_field("swing_c", out_word_o.swing_c, swing_q[0].swing_c);
        void'(swing_q.pop_front());
        swings_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles", quiet_cycles);
        $display("** decimated_peak_to_peak_meter: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [REG_W-1:0] scale_v;
    logic [REG_W-1:0] coeff_v;
    logic [REG_W-1:0] period_v;
    int unsigned      n_words;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_word_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    reg_scale  = SCALE_RST;
    reg_coeff  = COEFF_RST;
    reg_period = PERIOD_RST;
    tick_count = '0;
    clear_window();
    tx_gappy    = 1'b1;
    rx_gappy    = 1'b1;
    rx_hold_req = 1'b0;

    // At reset the scaling is the identity, so a window spanning 0 to 4095
    // on every channel reads 4095/16 - 0 = 255.
    add_sample(12'd0,    12'd4095, 12'd0);
    for (int k = 0; k < SAMPLE_W; k++) begin
      add_sample((k % 2) ? 12'd0 : 12'd4095, (k % 2) ? 12'd4095 : 12'd0,
                 SAMPLE_W'(1) << k);
    end
    add_sample(12'd4095, 12'd0,    12'd4095);
    add_sample(12'd0,    12'd4095, 12'hAAA);
    add_sample(12'd4095, 12'd0,    12'h555, 1'b1,
               '{swing_a: 16'd255, swing_b: 16'd255, swing_c: 16'd255});
    // Zero coefficient saturates every scaled sample.
    add_write(REG_COEFF, 16'd0);
    add_sample(12'd123,  12'd4095, 12'd0);
    add_sample(12'd0,    12'd1,    12'd2048);
    add_sample(12'd4095, 12'd4095, 12'd4095);
    // A zero decimation period accepts every tick.
    add_write(REG_PERIOD, 16'd0);
    add_sample(12'd7,    12'd300,  12'd4000);
    add_sample(12'd4095, 12'd0,    12'd1);
    // Largest scale over the smallest coefficient wraps the 16-bit value.
    add_write(REG_SCALE, 16'hFFFF);
    add_write(REG_COEFF, 16'd1);
    add_sample(12'd4095, 12'd1,    12'd2);
    add_sample(12'd0,    12'd4095, 12'd3);
    add_sample(12'd1,    12'd2,    12'd4095);
    add_sample(12'd2048, 12'd1024, 12'd0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        settle_block();
        write_register(directed_rows[r].reg_idx, directed_rows[r].value);
      end else begin
        send_and_predict(directed_rows[r].word, directed_rows[r].typed,
                         directed_rows[r].swing);
      end
    end

    // Random phases; the window carries over from one setting to the next.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle_block();
      n_words = PHASE_WORDS;
      case (phase)
        0: begin
          scale_v  = 16'($urandom_range(1, 8));
          coeff_v  = 16'd1000;
          period_v = 16'd1;
        end
        1: begin
          scale_v  = 16'hFFFF;
          coeff_v  = 16'hFFFF;
          period_v = 16'd2;
        end
        2: begin
          scale_v  = 16'd1;
          coeff_v  = 16'hFFFF;
          period_v = 16'd1;
        end
        3: begin
          scale_v  = 16'($urandom);
          coeff_v  = 16'd0;
          period_v = 16'd1;
        end
        4: begin
          // Longest period: the ticks are almost all dropped, so keep it short.
          scale_v  = 16'hFFFF;
          coeff_v  = 16'd1;
          period_v = 16'hFFFF;
          n_words  = 24;
        end
        5: begin
          scale_v  = 16'($urandom_range(1, 65535));
          coeff_v  = 16'($urandom_range(1, 65535));
          period_v = 16'd0;
        end
        6: begin
          scale_v  = 16'd0;
          coeff_v  = 16'($urandom_range(1, 65535));
          period_v = 16'd1;
        end
        default: begin
          scale_v  = $urandom_range(0, 1) ? 16'($urandom_range(1, 16))
                                          : 16'($urandom_range(1, 65535));
          coeff_v  = $urandom_range(0, 1) ? 16'($urandom_range(500, 4000))
                                          : 16'($urandom_range(1, 65535));
          period_v = 16'($urandom_range(1, 3));
        end
      endcase
      write_register(REG_SCALE,  scale_v);
      write_register(REG_COEFF,  coeff_v);
      write_register(REG_PERIOD, period_v);
      tx_gappy = ($urandom_range(0, 3) != 0);
      rx_gappy = ($urandom_range(0, 3) != 0);
      // Phase 0 backs the block up behind a long receiver hold.
      if (phase == 0) begin
        tx_gappy    = 1'b0;
        rx_hold_req = 1'b1;
      end
      for (int unsigned i = 0; i < n_words; i++) begin
        send_and_predict(make_word(spread_e'($urandom_range(0, 2))), 1'b0, '0);
      end
    end

    settle_block();
    $display("Sent %0d sample words under %0d register writes, incl. zero coefficient,",
             words_sent, settings_applied);
    $display("zero period, wrapped scaling and %0d long hold; %0d swing words checked.",
             holds_done, swings_checked);
    if (mismatches == 0) begin
      $display("** decimated_peak_to_peak_meter: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** decimated_peak_to_peak_meter: FAILED **");
    end
    $finish;
  end

endmodule
